>>> hdl/tebc_pkg.sv
// shared types, constants and rounding functions of the tilt estimate and balance controller
package tebc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned OPA_W  = 34;
  localparam int unsigned OPB_W  = 18;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned ACC_W  = 54;
  localparam int unsigned RND_W  = ACC_W - FRAC_W;
  localparam int unsigned ADDR_W = 5;

  localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [2:0] REG_BLEND  = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_B0     = 3'd2;
  localparam logic [2:0] REG_B1     = 3'd3;
  localparam logic [2:0] REG_B2     = 3'd4;
  localparam logic [2:0] REG_A1     = 3'd5;
  localparam logic [2:0] REG_A2     = 3'd6;

  localparam logic [16:0] BLEND_RST  = 17'd64225;
  localparam logic [15:0] PERIOD_RST = 16'd328;
  localparam logic [17:0] B0_RST     = 18'd6554;
  localparam logic [17:0] B1_RST     = 18'd13107;
  localparam logic [17:0] B2_RST     = 18'd6554;
  localparam logic [17:0] A1_RST     = 18'd65536;
  localparam logic [17:0] A2_RST     = 18'h38000;

  localparam logic [OPB_W-1:0] Q_ONE = OPB_W'(1 << FRAC_W);

  typedef struct packed {
    logic [16:0]       blend_weight;
    logic [15:0]       sample_period;
    logic signed [17:0] coef_b0;
    logic signed [17:0] coef_b1;
    logic signed [17:0] coef_b2;
    logic signed [17:0] coef_a1;
    logic signed [17:0] coef_a2;
  } cfg_t;

  typedef enum logic [2:0] {
    A_RATE, A_PRED, A_ACCEL, A_ENEW, A_E1, A_E2, A_Y1, A_Y2
  } a_sel_e;

  typedef enum logic [2:0] {
    B_DT, B_ALPHA, B_REST, B_B0, B_B1, B_B2, B_A1, B_A2
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef struct packed {
    logic    capture;
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    logic    pred_en;
    logic    est_en;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } stat_t;

  // round to nearest, half toward plus infinity
  function automatic logic signed [RND_W-1:0] rnd(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(1 << (FRAC_W - 1));
    return RND_W'(t >>> FRAC_W);
  endfunction

  function automatic logic [DATA_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [RND_W-1:0]    r;
    logic [RND_W-DATA_W:0]      hi;
    r  = rnd(v);
    hi = r[RND_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return r[DATA_W-1:0];
    end else if (r[RND_W-1]) begin
      return INT_MIN;
    end else begin
      return INT_MAX;
    end
  endfunction

endpackage

>>> hdl/tebc_regs.sv
// configuration register file behind the apb port
module tebc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tebc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tebc_pkg::cfg_t              cfg_o
);
  import tebc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr;
  logic [2:0] idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_BLEND:  cfg_d.blend_weight  = pwdata[16:0];
        REG_PERIOD: cfg_d.sample_period = pwdata[15:0];
        REG_B0:     cfg_d.coef_b0       = pwdata[17:0];
        REG_B1:     cfg_d.coef_b1       = pwdata[17:0];
        REG_B2:     cfg_d.coef_b2       = pwdata[17:0];
        REG_A1:     cfg_d.coef_a1       = pwdata[17:0];
        REG_A2:     cfg_d.coef_a2       = pwdata[17:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BLEND:  prdata = {15'd0, cfg_q.blend_weight};
      REG_PERIOD: prdata = {16'd0, cfg_q.sample_period};
      REG_B0:     prdata = 32'(cfg_q.coef_b0);
      REG_B1:     prdata = 32'(cfg_q.coef_b1);
      REG_B2:     prdata = 32'(cfg_q.coef_b2);
      REG_A1:     prdata = 32'(cfg_q.coef_a1);
      REG_A2:     prdata = 32'(cfg_q.coef_a2);
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_weight  <= BLEND_RST;
      cfg_q.sample_period <= PERIOD_RST;
      cfg_q.coef_b0       <= B0_RST;
      cfg_q.coef_b1       <= B1_RST;
      cfg_q.coef_b2       <= B2_RST;
      cfg_q.coef_a1       <= A1_RST;
      cfg_q.coef_a2       <= A2_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/tebc_dp.sv
// datapath: shared multiplier, accumulator, filter state and result register
module tebc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tebc_pkg::cfg_t              cfg_i,
  input  tebc_pkg::cmd_t              cmd_i,
  output tebc_pkg::stat_t             stat_o,
  input  logic [tebc_pkg::DATA_W-1:0] gyro_rate_i,
  input  logic [tebc_pkg::DATA_W-1:0] accel_angle_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tebc_pkg::DATA_W-1:0] drive_value_o,
  output logic [tebc_pkg::DATA_W-1:0] tilt_estimate_o
);
  import tebc_pkg::*;

  logic signed [DATA_W-1:0] gyro_q, accel_q;
  logic signed [DATA_W-1:0] est_q, e1_q, e2_q, y1_q, y2_q;
  logic signed [DATA_W-1:0] enew, unew;
  logic signed [OPA_W-1:0]  pred_q, op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d, prod_ext;
  logic signed [RND_W-1:0]  pred_sum;
  logic [DATA_W-1:0]        drive_q, tilt_q;
  logic                     out_valid_q, out_valid_d;

  assign enew = (est_q == INT_MIN) ? INT_MAX : -est_q;
  assign unew = rnd_sat(acc_q);

  always_comb begin
    case (cmd_i.a_sel)
      A_RATE:  op_a = OPA_W'(gyro_q);
      A_PRED:  op_a = pred_q;
      A_ACCEL: op_a = OPA_W'(accel_q);
      A_ENEW:  op_a = OPA_W'(enew);
      A_E1:    op_a = OPA_W'(e1_q);
      A_E2:    op_a = OPA_W'(e2_q);
      A_Y1:    op_a = OPA_W'(y1_q);
      A_Y2:    op_a = OPA_W'(y2_q);
      default: op_a = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.b_sel)
      B_DT:    op_b = {2'b00, cfg_i.sample_period};
      B_ALPHA: op_b = {1'b0, cfg_i.blend_weight};
      B_REST:  op_b = Q_ONE - {1'b0, cfg_i.blend_weight};
      B_B0:    op_b = cfg_i.coef_b0;
      B_B1:    op_b = cfg_i.coef_b1;
      B_B2:    op_b = cfg_i.coef_b2;
      B_A1:    op_b = cfg_i.coef_a1;
      B_A2:    op_b = cfg_i.coef_a2;
      default: op_b = '0;
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign prod_ext = ACC_W'(prod_q);
  assign pred_sum = rnd(prod_ext) + RND_W'(est_q);

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LOAD: acc_d = prod_ext;
      ACC_ADD:  acc_d = acc_q + prod_ext;
      ACC_SUB:  acc_d = acc_q - prod_ext;
      default:  acc_d = acc_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign stat_o.out_stall = out_valid_q & ~out_ready_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.capture) begin
      gyro_q  <= gyro_rate_i;
      accel_q <= accel_angle_i;
    end
    if (cmd_i.pred_en) begin
      pred_q <= pred_sum[OPA_W-1:0];
    end
    if (cmd_i.out_load) begin
      drive_q <= unew;
      tilt_q  <= est_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q       <= '0;
      e1_q        <= '0;
      e2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.est_en) begin
        est_q <= rnd_sat(acc_q);
      end
      if (cmd_i.out_load) begin
        e2_q <= e1_q;
        e1_q <= enew;
        y2_q <= y1_q;
        y1_q <= unew;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_value_o   = drive_q;
  assign tilt_estimate_o = tilt_q;

endmodule

>>> hdl/tebc_ctrl.sv
// sequencer that steps the shared multiplier through the filter and the biquad
module tebc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tebc_pkg::stat_t  stat_i,
  output tebc_pkg::cmd_t   cmd_o
);
  import tebc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MRD  = 4'd1;
  localparam logic [3:0] S_PRED = 4'd2;
  localparam logic [3:0] S_MAP  = 4'd3;
  localparam logic [3:0] S_MRA  = 4'd4;
  localparam logic [3:0] S_FACC = 4'd5;
  localparam logic [3:0] S_EST  = 4'd6;
  localparam logic [3:0] S_MB0  = 4'd7;
  localparam logic [3:0] S_MB1  = 4'd8;
  localparam logic [3:0] S_MB2  = 4'd9;
  localparam logic [3:0] S_MA1  = 4'd10;
  localparam logic [3:0] S_MA2  = 4'd11;
  localparam logic [3:0] S_LAST = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.a_sel    = A_RATE;
    cmd_o.b_sel    = B_DT;
    cmd_o.acc_op   = ACC_HOLD;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        state_d = S_PRED;
      end
      S_PRED: begin
        cmd_o.pred_en = 1'b1;
        state_d       = S_MAP;
      end
      S_MAP: begin
        cmd_o.a_sel = A_PRED;
        cmd_o.b_sel = B_ALPHA;
        state_d     = S_MRA;
      end
      S_MRA: begin
        cmd_o.a_sel  = A_ACCEL;
        cmd_o.b_sel  = B_REST;
        cmd_o.acc_op = ACC_LOAD;
        state_d      = S_FACC;
      end
      S_FACC: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_EST;
      end
      S_EST: begin
        cmd_o.est_en = 1'b1;
        state_d      = S_MB0;
      end
      S_MB0: begin
        cmd_o.a_sel = A_ENEW;
        cmd_o.b_sel = B_B0;
        state_d     = S_MB1;
      end
      S_MB1: begin
        cmd_o.a_sel  = A_E1;
        cmd_o.b_sel  = B_B1;
        cmd_o.acc_op = ACC_LOAD;
        state_d      = S_MB2;
      end
      S_MB2: begin
        cmd_o.a_sel  = A_E2;
        cmd_o.b_sel  = B_B2;
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_MA1;
      end
      S_MA1: begin
        cmd_o.a_sel  = A_Y1;
        cmd_o.b_sel  = B_A1;
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_MA2;
      end
      S_MA2: begin
        cmd_o.a_sel  = A_Y2;
        cmd_o.b_sel  = B_A2;
        cmd_o.acc_op = ACC_SUB;
        state_d      = S_LAST;
      end
      S_LAST: begin
        cmd_o.acc_op = ACC_SUB;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!stat_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MRD))
    else $error("transfer did not start the sequence");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && stat_i.out_stall) |=> (state_q == S_OUT))
    else $error("result dropped while output register full");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!stat_i.out_stall && state_q == S_OUT))
    else $error("result loaded over a waiting one");

  a_state_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.est_en || cmd_o.pred_en) |-> !in_ready_o)
    else $error("state update outside the sequence");
`endif

endmodule

>>> hdl/tilt_estimate_and_balance_controller.sv
// one item at a time: a new input transfer is taken only once the sequencer has loaded the last result
// one shared 34x18 multiplier takes the eight products of each item in turn
// a finished result waits in the output register while the next item is taken in
// reset: asynchronous active low, clears the estimate, the biquad delays and the handshake
// state, and loads the default blend weight, sample period and coefficients
module tilt_estimate_and_balance_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tebc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tebc_pkg::DATA_W-1:0] gyro_rate_i,
  input  logic [tebc_pkg::DATA_W-1:0] accel_angle_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tebc_pkg::DATA_W-1:0] drive_value_o,
  output logic [tebc_pkg::DATA_W-1:0] tilt_estimate_o
);
  import tebc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tebc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tebc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tebc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .gyro_rate_i     (gyro_rate_i),
    .accel_angle_i   (accel_angle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_value_o   (drive_value_o),
    .tilt_estimate_o (tilt_estimate_o)
  );

endmodule

>>> bench/testbench.sv
// self-checking testbench for the tilt estimate and balance controller
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tebc_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 144;
  localparam int REPORT_LINES  = 40;

  localparam logic [2:0] REG_NONE = 3'd7;

  typedef enum int {SET_DEFAULT, SET_HIGH, SET_LOW, SET_RANDOM} setting_e;

  typedef struct packed {
    logic [31:0] gyro;
    logic [31:0] accel;
  } imu_sample_t;

  typedef struct packed {
    logic [31:0] drive;
    logic [31:0] tilt;
  } ctrl_out_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [31:0] gyro_rate_i   = '0;
  logic [31:0] accel_angle_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [31:0] drive_value_o;
  logic [31:0] tilt_estimate_o;

  // predictor state and register copy
  cfg_t cfg_copy = '{BLEND_RST, PERIOD_RST, B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};
  logic signed [31:0] tilt_state = '0;
  logic signed [31:0] err_d1     = '0;
  logic signed [31:0] err_d2     = '0;
  logic signed [31:0] drv_d1     = '0;
  logic signed [31:0] drv_d2     = '0;

  imu_sample_t imu_samples_q[$];
  ctrl_out_t   drive_tilt_q[$];
  imu_sample_t staged;
  ctrl_out_t   wanted;

  logic in_accept    = 1'b0;
  logic src_idle_en  = 1'b1;
  logic sink_idle_en = 1'b1;
  logic hold_request = 1'b0;
  logic hold_done    = 1'b0;
  int   src_wait     = 0;
  int   sink_wait    = 0;
  int   sink_draw    = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;
  int   samples_sent = 0;
  int   results_seen = 0;
  int   cfg_writes   = 0;
  int   settings_run = 0;
  int   mismatches   = 0;

  tilt_estimate_and_balance_controller DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .gyro_rate_i    (gyro_rate_i),
    .accel_angle_i  (accel_angle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_value_o  (drive_value_o),
    .tilt_estimate_o(tilt_estimate_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic longint q16_round(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [31:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return INT_MAX;
    end
    if (v < -64'sd2147483648) begin
      return INT_MIN;
    end
    return v[31:0];
  endfunction

  function automatic ctrl_out_t balance_step(input logic [31:0] gyro, input logic [31:0] accel);
    longint alpha, pred, acc, u;
    logic [31:0] est, err, drv;
    alpha = longint'(cfg_copy.blend_weight);
    pred  = longint'(tilt_state)
          + q16_round(longint'($signed(gyro)) * longint'(cfg_copy.sample_period));
    acc   = alpha * pred + (longint'(Q_ONE) - alpha) * longint'($signed(accel));
    est   = clamp_s32(q16_round(acc));
    err   = clamp_s32(-longint'($signed(est)));
    u     = longint'(cfg_copy.coef_b0) * longint'($signed(err))
          + longint'(cfg_copy.coef_b1) * longint'(err_d1)
          + longint'(cfg_copy.coef_b2) * longint'(err_d2)
          - longint'(cfg_copy.coef_a1) * longint'(drv_d1)
          - longint'(cfg_copy.coef_a2) * longint'(drv_d2);
    drv   = clamp_s32(q16_round(u));
    tilt_state = est;
    err_d2     = err_d1;
    err_d1     = err;
    drv_d2     = drv_d1;
    drv_d1     = drv;
    return '{drv, est};
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_BLEND:  cfg_copy.blend_weight  = data[16:0];
      REG_PERIOD: cfg_copy.sample_period = data[15:0];
      REG_B0:     cfg_copy.coef_b0       = data[17:0];
      REG_B1:     cfg_copy.coef_b1       = data[17:0];
      REG_B2:     cfg_copy.coef_b2       = data[17:0];
      REG_A1:     cfg_copy.coef_a1       = data[17:0];
      REG_A2:     cfg_copy.coef_a2       = data[17:0];
      default: ;
    endcase
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    int s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return INT_MAX;
          1: return INT_MIN;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: begin
        s = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        return s;
      end
    endcase
  endfunction

  function automatic logic [17:0] rand_coef();
    int s;
    case ($urandom_range(0, 5))
      0: return 18'h20000;
      1: return 18'h1FFFF;
      2, 3: begin
        s = int'($urandom_range(0, 65536)) - 32768;
        return s[17:0];
      end
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic cfg_t pick_cfg(input setting_e mode);
    cfg_t c;
    case (mode)
      SET_DEFAULT: c = '{BLEND_RST, PERIOD_RST, B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};
      SET_HIGH: c = '{17'd65536, 16'hFFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                      18'h1FFFF};
      SET_LOW: c = '{17'd0, 16'd0, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000};
      default: begin
        c.blend_weight  = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(65537, 131071))
                                                        : 17'($urandom_range(0, 65536));
        c.sample_period = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2000))
                                                        : 16'($urandom);
        c.coef_b0 = rand_coef();
        c.coef_b1 = rand_coef();
        c.coef_b2 = rand_coef();
        c.coef_a1 = rand_coef();
        c.coef_a2 = rand_coef();
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < REPORT_LINES) begin
      $display("mismatch on %s after %0d results: got %h, want %h", what, results_seen,
               got, want);
    end
    mismatches++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val,
                           input logic [31:0] keep);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom & ~keep) | (val & keep);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, pwdata);
    cfg_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_cfg(input cfg_t c);
    write_reg(REG_BLEND, 32'(c.blend_weight), 32'h1FFFF);
    write_reg(REG_PERIOD, 32'(c.sample_period), 32'hFFFF);
    write_reg(REG_B0, 32'(c.coef_b0), 32'h3FFFF);
    write_reg(REG_B1, 32'(c.coef_b1), 32'h3FFFF);
    write_reg(REG_B2, 32'(c.coef_b2), 32'h3FFFF);
    write_reg(REG_A1, 32'(c.coef_a1), 32'h3FFFF);
    write_reg(REG_A2, 32'(c.coef_a2), 32'h3FFFF);
    settings_run++;
  endtask

  task automatic push_sample(input logic [31:0] gyro, input logic [31:0] accel);
    imu_samples_q.push_back('{gyro, accel});
  endtask

  task automatic drain();
    while (imu_samples_q.size() > 0 || in_valid_i || drive_tilt_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // sample driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_accept) begin
      end else if (src_wait > 0) begin
        in_valid_i <= 1'b0;
        src_wait--;
      end else if (imu_samples_q.size() > 0) begin
        staged = imu_samples_q.pop_front();
        in_valid_i    <= 1'b1;
        gyro_rate_i   <= staged.gyro;
        accel_angle_i <= staged.accel;
        src_wait = src_idle_en ? idle_len() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with the one long hold-off
  always @(negedge clk_i) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (sink_wait > 0) begin
      out_ready_i <= 1'b0;
      sink_wait--;
    end else begin
      sink_draw = sink_idle_en ? idle_len() : 0;
      if (sink_draw > 0) begin
        sink_wait = sink_draw - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // input transfer: predict the result
  always @(posedge clk_i) begin
    in_accept <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      drive_tilt_q.push_back(balance_step(gyro_rate_i, accel_angle_i));
      samples_sent++;
    end
  end

  // output transfer: compare
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_tilt_q.size() == 0) begin
        report_mismatch("result with nothing pending", drive_value_o, 'x);
      end else begin
        wanted = drive_tilt_q.pop_front();
        if (drive_value_o !== wanted.drive) begin
          report_mismatch("drive_value", drive_value_o, wanted.drive);
        end
        if (tilt_estimate_o !== wanted.tilt) begin
          report_mismatch("tilt_estimate", tilt_estimate_o, wanted.tilt);
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tilt_estimate_and_balance_controller verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t setting;
    setting_e mode;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, field extremes
    push_sample('0, '0);
    push_sample(INT_MAX, '0);
    push_sample(INT_MIN, '0);
    push_sample('0, INT_MAX);
    push_sample('0, INT_MIN);
    push_sample(INT_MAX, INT_MAX);
    push_sample(INT_MIN, INT_MIN);
    push_sample(32'd1, '1);
    push_sample('1, 32'd1);
    push_sample(32'h0001_0000, 32'hFFFF_0000);
    drain();

    // accel only: most negative estimate, saturated error and drive
    setting = '{17'd0, 16'hFFFF, 18'h1FFFF, 18'h20000, 18'd0, 18'd0, 18'd0};
    write_cfg(setting);
    push_sample('0, INT_MIN);
    push_sample('0, INT_MIN);
    push_sample('0, INT_MAX);
    push_sample('1, INT_MIN);
    push_sample('0, 32'd1);
    push_sample('0, '1);
    drain();

    // weight above one, coefficient extremes, unused register slot
    setting = '{17'h1FFFF, 16'hFFFF, 18'h20000, 18'h1FFFF, 18'h3FFFF, 18'h20000, 18'h1FFFF};
    write_cfg(setting);
    write_reg(REG_NONE, '0, '0);
    push_sample(INT_MAX, INT_MIN);
    push_sample(INT_MIN, INT_MAX);
    push_sample('0, '0);
    push_sample(32'd12345, -32'sd6789);
    drain();

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0, 4:    mode = SET_DEFAULT;
        2:       mode = SET_HIGH;
        5:       mode = SET_LOW;
        default: mode = SET_RANDOM;
      endcase
      src_idle_en  = (k % 4 == 0) || (k % 4 == 2);
      sink_idle_en = (k % 4 == 0) || (k % 4 == 3);
      write_cfg(pick_cfg(mode));
      if (k == 1) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_sample(rand_word(), rand_word());
      end
      drain();
    end

    $display("%0d imu samples over %0d register settings, %0d results compared, %0d writes",
             samples_sent, settings_run, results_seen, cfg_writes);
    $display("covered field extremes, weight above one, saturation and a long output hold-off");
    if (mismatches == 0 && drive_tilt_q.size() == 0) begin
      $display("tilt_estimate_and_balance_controller verification clean");
    end else begin
      $display("tilt_estimate_and_balance_controller verification failed");
    end
    $finish;
  end

endmodule
